@@ rtl/rcmp_pkg.sv @@
// Shared types, constants and codes for the remapped checked memory port.
package rcmp_pkg;

   // Default sizes handed down from the top level
   localparam int MAP_SLOTS_DEF = 4;
   localparam int ROM_WORDS_DEF = 16384;
   localparam int RAM_WORDS     = 2048;

   // Action codes
   localparam logic [2:0] ACT_READ       = 3'd0;
   localparam logic [2:0] ACT_WRITE      = 3'd1;
   localparam logic [2:0] ACT_RAW_LOAD   = 3'd2;
   localparam logic [2:0] ACT_MAP_ADD    = 3'd3;
   localparam logic [2:0] ACT_MAP_REMOVE = 3'd4;

   // Access size codes; anything above halfword is a word access
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   // Fault codes
   localparam logic [2:0] FAULT_NONE      = 3'd0;
   localparam logic [2:0] FAULT_UNALIGNED = 3'd1;
   localparam logic [2:0] FAULT_ROM_WRITE = 3'd2;
   localparam logic [2:0] FAULT_BAD_SRAM  = 3'd3;
   localparam logic [2:0] FAULT_MAP_FULL  = 3'd4;

   // Address map: top nibble selects the region
   localparam logic [3:0]  REGION_ROM_LO = 4'h0;
   localparam logic [3:0]  REGION_ROM_HI = 4'h1;
   localparam logic [3:0]  REGION_RAM_LO = 4'h2;
   localparam logic [3:0]  REGION_RAM_HI = 4'h3;
   localparam logic [31:0] RAM_LIMIT     = 32'h2000_2000;
   localparam logic [29:0] RAM_WORD_BASE = 30'h0800_0000;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] addr;
      logic [1:0]  size_code;
      logic [31:0] write_data;
      logic [31:0] map_target;
      logic [31:0] map_length;
      logic [1:0]  map_slot;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  fault;
      logic [1:0]  slot_index;
   } rsp_type;

   // Remap table update request
   typedef struct packed {
      logic        add;
      logic        remove;
      logic [31:0] base;
      logic [31:0] target;
      logic [31:0] length;
      logic [1:0]  slot;
   } map_upd_type;

   // Outcome of a slot search for an add
   typedef struct packed {
      logic       full;
      logic [1:0] slot_index;
   } map_add_type;

   // One word access to the backing stores
   typedef struct packed {
      logic        en;
      logic        we;
      logic [3:0]  be;
      logic [29:0] word;
      logic [31:0] data;
   } mem_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_XLATE,
      ST_CHECK,
      ST_RDATA,
      ST_LOAD_LO,
      ST_LOAD_HI,
      ST_DONE
   } state_type;

endpackage

@@ rtl/rcmp_map_table.sv @@
// Remap slot table: address translation, free slot search and slot updates.
module rcmp_map_table import rcmp_pkg::*; #(
   parameter int MAP_SLOTS = MAP_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] lookup_addr,
   output logic [31:0] xlate_addr,
   input  map_upd_type upd,
   output map_add_type add_res
);

   localparam int SLOT_W = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;

   logic [31:0] src_base_ff [MAP_SLOTS];
   logic [31:0] dest_base_ff [MAP_SLOTS];
   logic [31:0] win_len_ff [MAP_SLOTS];

   logic [31:0]       offs [MAP_SLOTS];
   logic [MAP_SLOTS-1:0] hit;
   logic              hit_found;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic              rm_ok;
   logic [SLOT_W-1:0] rm_idx;

   always_comb begin
      for (int i = 0; i < MAP_SLOTS; i++) begin
         offs[i] = lookup_addr - src_base_ff[i];
         hit[i]  = (win_len_ff[i] != '0) && (offs[i] < win_len_ff[i]);
      end
   end

   // Lowest occupied slot whose window holds the address wins
   always_comb begin
      hit_found  = 1'b0;
      xlate_addr = lookup_addr;
      for (int i = 0; i < MAP_SLOTS; i++) begin
         if (!hit_found && hit[i]) begin
            hit_found  = 1'b1;
            xlate_addr = offs[i] + dest_base_ff[i];
         end
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < MAP_SLOTS; i++) begin
         if (!free_found && (win_len_ff[i] == '0)) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign add_res.full       = !free_found;
   assign add_res.slot_index = free_found ? 2'(free_idx) : 2'd0;

   assign rm_ok  = int'(upd.slot) < MAP_SLOTS;
   assign rm_idx = SLOT_W'(upd.slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_SLOTS; i++) begin
            win_len_ff[i] <= '0;
         end
      end else begin
         if (upd.add && free_found) begin
            win_len_ff[free_idx] <= upd.length;
         end
         if (upd.remove && rm_ok) begin
            win_len_ff[rm_idx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.add && free_found) begin
         src_base_ff[free_idx]  <= upd.base;
         dest_base_ff[free_idx] <= upd.target;
      end
   end

endmodule

@@ rtl/rcmp_store.sv @@
// ROM and RAM word stores with byte enables, region decode and clearing sweep.
module rcmp_store import rcmp_pkg::*; #(
   parameter int ROM_WORDS = ROM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   output logic        clear_busy,
   output logic [31:0] rdata
);

   localparam int ROM_AW    = $clog2(ROM_WORDS);
   localparam int RAM_AW    = $clog2(RAM_WORDS);
   localparam int CLR_WORDS = (ROM_WORDS > RAM_WORDS) ? ROM_WORDS : RAM_WORDS;
   localparam int CLR_AW    = $clog2(CLR_WORDS);

   logic [31:0] rom_mem [ROM_WORDS];
   logic [31:0] ram_mem [RAM_WORDS];

   logic [CLR_AW-1:0] clr_cnt_ff;
   logic              busy_ff;

   logic        rom_hit;
   logic        ram_hit;
   logic [29:0] ram_off;

   logic              rom_we;
   logic [ROM_AW-1:0] rom_idx;
   logic [3:0]        rom_be;
   logic [31:0]       rom_wd;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_idx;
   logic [3:0]        ram_be;
   logic [31:0]       ram_wd;

   logic [31:0] rom_q_ff;
   logic [31:0] ram_q_ff;
   logic        rom_sel_ff;
   logic        ram_sel_ff;

   // Words below ROM_WORDS are ROM; RAM sits at its own word base
   assign rom_hit = cmd.word < 30'(ROM_WORDS);
   assign ram_off = cmd.word - RAM_WORD_BASE;
   assign ram_hit = ram_off < 30'(RAM_WORDS);

   always_comb begin
      if (busy_ff) begin
         rom_we  = {1'b0, clr_cnt_ff} < (CLR_AW + 1)'(ROM_WORDS);
         rom_idx = clr_cnt_ff[ROM_AW-1:0];
         rom_be  = 4'b1111;
         rom_wd  = '0;
         ram_we  = {1'b0, clr_cnt_ff} < (CLR_AW + 1)'(RAM_WORDS);
         ram_idx = clr_cnt_ff[RAM_AW-1:0];
         ram_be  = 4'b1111;
         ram_wd  = '0;
      end else begin
         rom_we  = cmd.en && cmd.we && rom_hit;
         rom_idx = cmd.word[ROM_AW-1:0];
         rom_be  = cmd.be;
         rom_wd  = cmd.data;
         ram_we  = cmd.en && cmd.we && ram_hit;
         ram_idx = ram_off[RAM_AW-1:0];
         ram_be  = cmd.be;
         ram_wd  = cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rom_we) begin
         for (int b = 0; b < 4; b++) begin
            if (rom_be[b]) begin
               rom_mem[rom_idx][8*b +: 8] <= rom_wd[8*b +: 8];
            end
         end
      end
      rom_q_ff <= rom_mem[rom_idx];
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         for (int b = 0; b < 4; b++) begin
            if (ram_be[b]) begin
               ram_mem[ram_idx][8*b +: 8] <= ram_wd[8*b +: 8];
            end
         end
      end
      ram_q_ff <= ram_mem[ram_idx];
   end

   always_ff @(posedge clock) begin
      rom_sel_ff <= cmd.en && !cmd.we && rom_hit;
      ram_sel_ff <= cmd.en && !cmd.we && ram_hit;
   end

   // Unbacked words read as zero
   assign rdata = rom_sel_ff ? rom_q_ff : (ram_sel_ff ? ram_q_ff : 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else if (busy_ff) begin
         if (clr_cnt_ff == CLR_AW'(CLR_WORDS - 1)) begin
            busy_ff <= 1'b0;
         end
         clr_cnt_ff <= clr_cnt_ff + CLR_AW'(1);
      end
   end

   assign clear_busy = busy_ff;

endmodule

@@ rtl/remapped_checked_memory_port_core.sv @@
// Top level of the remapped checked memory port: request sequencer and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_data (req_type)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_data (rsp_type)
//
// One request is in work at a time: XLATE, then DONE for map add/remove and unused
// actions; CHECK, DONE for writes and faults; CHECK, RDATA, DONE for reads; LOAD_LO,
// LOAD_HI (when the four bytes span two words), DONE for raw loads. DONE loads the
// output register; the next request is taken in IDLE after it. A reset sweep over
// max(ROM_WORDS, 2048) words zeroes both stores before any request. A stalled result
// holds in the output register and a finished request waits behind it.
module remapped_checked_memory_port_core import rcmp_pkg::*; #(
   parameter int MAP_SLOTS = MAP_SLOTS_DEF,
   parameter int ROM_WORDS = ROM_WORDS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   req_type     req_ff;
   logic [31:0] xaddr_ff;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic take_req;
   logic xaddr_ld;
   logic res_ld;
   logic rsp_ld;

   logic [31:0] xlate_addr;
   map_upd_type map_upd;
   map_add_type add_res;
   mem_cmd_type mem_cmd;
   logic        clear_busy;
   logic [31:0] store_rdata;

   logic [3:0]  size_be;
   logic        align_bad;
   logic [3:0]  region;
   logic        is_write;
   logic [2:0]  chk_fault;
   logic [31:0] rd_shift;
   logic [31:0] rd_mask;
   logic [1:0]  ld_off;
   logic [3:0]  ld_be_lo;
   logic [29:0] ld_word_lo;

   rcmp_map_table #(
      .MAP_SLOTS(MAP_SLOTS)
   ) u_map_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_addr(req_ff.addr),
      .xlate_addr (xlate_addr),
      .upd        (map_upd),
      .add_res    (add_res)
   );

   rcmp_store #(
      .ROM_WORDS(ROM_WORDS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (mem_cmd),
      .clear_busy(clear_busy),
      .rdata     (store_rdata)
   );

   // Access checks on the translated address
   always_comb begin
      case (req_ff.size_code)
         SIZE_BYTE: size_be = 4'b0001;
         SIZE_HALF: size_be = 4'b0011;
         default:   size_be = 4'b1111;
      endcase
   end

   always_comb begin
      case (req_ff.size_code)
         SIZE_BYTE: align_bad = 1'b0;
         SIZE_HALF: align_bad = xaddr_ff[0];
         default:   align_bad = |xaddr_ff[1:0];
      endcase
   end

   assign region   = xaddr_ff[31:28];
   assign is_write = req_ff.action == ACT_WRITE;

   always_comb begin
      if (align_bad) begin
         chk_fault = FAULT_UNALIGNED;
      end else if ((region == REGION_ROM_LO || region == REGION_ROM_HI) && is_write) begin
         chk_fault = FAULT_ROM_WRITE;
      end else if ((region == REGION_RAM_LO || region == REGION_RAM_HI) &&
                   xaddr_ff >= RAM_LIMIT) begin
         chk_fault = FAULT_BAD_SRAM;
      end else begin
         chk_fault = FAULT_NONE;
      end
   end

   assign rd_shift = store_rdata >> {xaddr_ff[1:0], 3'b000};
   assign rd_mask  = {{8{size_be[3]}}, {8{size_be[2]}}, {8{size_be[1]}}, {8{size_be[0]}}};

   // Raw load splits into a low word and, when unaligned, the next word
   assign ld_off     = req_ff.addr[1:0];
   assign ld_word_lo = req_ff.addr[31:2];
   assign ld_be_lo   = 4'b1111 << ld_off;

   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      take_req = 1'b0;
      xaddr_ld = 1'b0;
      res_ld = 1'b0;
      res_in = '0;
      rsp_ld = 1'b0;
      mem_cmd = '0;
      map_upd.add = 1'b0;
      map_upd.remove = 1'b0;
      map_upd.base = req_ff.addr;
      map_upd.target = req_ff.map_target;
      map_upd.length = req_ff.map_length;
      map_upd.slot = req_ff.map_slot;

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               take_req = 1'b1;
               state_in = ST_XLATE;
            end
         end
         ST_XLATE: begin
            res_ld = 1'b1;
            case (req_ff.action) inside
               ACT_READ, ACT_WRITE: begin
                  xaddr_ld = 1'b1;
                  state_in = ST_CHECK;
               end
               ACT_RAW_LOAD: begin
                  state_in = ST_LOAD_LO;
               end
               ACT_MAP_ADD: begin
                  map_upd.add = 1'b1;
                  res_in.fault = add_res.full ? FAULT_MAP_FULL : FAULT_NONE;
                  res_in.slot_index = add_res.slot_index;
                  state_in = ST_DONE;
               end
               ACT_MAP_REMOVE: begin
                  map_upd.remove = 1'b1;
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CHECK: begin
            if (chk_fault != FAULT_NONE) begin
               res_ld = 1'b1;
               res_in.fault = chk_fault;
               state_in = ST_DONE;
            end else begin
               mem_cmd.en = 1'b1;
               mem_cmd.we = is_write;
               mem_cmd.be = size_be << xaddr_ff[1:0];
               mem_cmd.word = xaddr_ff[31:2];
               mem_cmd.data = req_ff.write_data << {xaddr_ff[1:0], 3'b000};
               state_in = is_write ? ST_DONE : ST_RDATA;
            end
         end
         ST_RDATA: begin
            res_ld = 1'b1;
            res_in.read_data = rd_shift & rd_mask;
            state_in = ST_DONE;
         end
         ST_LOAD_LO: begin
            mem_cmd.en = 1'b1;
            mem_cmd.we = 1'b1;
            mem_cmd.be = ld_be_lo;
            mem_cmd.word = ld_word_lo;
            mem_cmd.data = req_ff.write_data << {ld_off, 3'b000};
            state_in = (ld_off == 2'd0) ? ST_DONE : ST_LOAD_HI;
         end
         ST_LOAD_HI: begin
            // Spill the upper bytes into the next word, wrapping at the top
            mem_cmd.en = 1'b1;
            mem_cmd.we = 1'b1;
            mem_cmd.be = ~ld_be_lo;
            mem_cmd.word = ld_word_lo + 30'd1;
            mem_cmd.data = req_ff.write_data >> {2'd0 - ld_off, 3'b000};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ld = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         req_ff <= req_data;
      end
      if (xaddr_ld) begin
         xaddr_ff <= xlate_addr;
      end
      if (res_ld) begin
         res_ff <= res_in;
      end
      if (rsp_ld) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ dv/tb_remapped_checked_memory_port_core.sv @@
// Self-checking testbench for the remapped checked memory port core.
module tb_remapped_checked_memory_port_core import rcmp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAP_SLOTS       = MAP_SLOTS_DEF;
   localparam int          ROM_WORDS       = ROM_WORDS_DEF;
   localparam logic [31:0] RAM_BASE        = {REGION_RAM_LO, 28'h0};
   localparam logic [31:0] ROM_END         = 4 * ROM_WORDS;
   localparam logic [31:0] MAP_SRC_AREA    = 32'h4000_0000;
   localparam logic [1:0]  SIZE_WORD       = SIZE_HALF + 2'd1;
   localparam logic [1:0]  SIZE_ODD        = SIZE_WORD + 2'd1;
   localparam int          RANDOM_REQUESTS = 1400;
   localparam int          IDLE_LIMIT      = 100000;
   localparam int          DRAIN_CYCLES    = 32;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   bit calm;
   int idle_cycles = 0;

   class access_scoreboard;
      bit [31:0] src_base [MAP_SLOTS];
      bit [31:0] dst_base [MAP_SLOTS];
      bit [31:0] win_len  [MAP_SLOTS];
      bit [31:0] rom_mem  [ROM_WORDS];
      bit [31:0] ram_mem  [RAM_WORDS];
      rsp_type   pending_rsp [$];
      int        errors;

      function bit [7:0] peek_byte(bit [31:0] a);
         bit [31:0] ram_off;
         ram_off = a - RAM_BASE;
         if (a < RAM_BASE) begin
            if (a < ROM_END) return 8'(rom_mem[a >> 2] >> (8 * a[1:0]));
         end else if (ram_off < 4 * RAM_WORDS) begin
            return 8'(ram_mem[ram_off >> 2] >> (8 * a[1:0]));
         end
         return 8'h00;
      endfunction

      // drop bytes that land outside both stores
      function void poke_byte(bit [31:0] a, bit [7:0] v);
         bit [31:0] ram_off;
         bit [31:0] mask;
         bit [31:0] lane;
         ram_off = a - RAM_BASE;
         mask    = 32'hFF << (8 * a[1:0]);
         lane    = {24'h0, v} << (8 * a[1:0]);
         if (a < RAM_BASE) begin
            if (a < ROM_END) rom_mem[a >> 2] = (rom_mem[a >> 2] & ~mask) | lane;
         end else if (ram_off < 4 * RAM_WORDS) begin
            ram_mem[ram_off >> 2] = (ram_mem[ram_off >> 2] & ~mask) | lane;
         end
      endfunction

      // first occupied slot whose window holds the address wins
      function bit [31:0] remap(bit [31:0] a);
         bit [31:0] off;
         for (int i = 0; i < MAP_SLOTS; i++) begin
            off = a - src_base[i];
            if (win_len[i] != 0 && off < win_len[i]) return off + dst_base[i];
         end
         return a;
      endfunction

      function logic [2:0] access_fault(bit [31:0] a, int nbytes, bit is_write);
         bit [31:0] lsb_mask;
         lsb_mask = nbytes - 1;
         if ((a & lsb_mask) != 0) return FAULT_UNALIGNED;
         if ((a[31:28] == REGION_ROM_LO || a[31:28] == REGION_ROM_HI) && is_write)
            return FAULT_ROM_WRITE;
         if ((a[31:28] == REGION_RAM_LO || a[31:28] == REGION_RAM_HI) && a >= RAM_LIMIT)
            return FAULT_BAD_SRAM;
         return FAULT_NONE;
      endfunction

      function void note_request(req_type r);
         rsp_type   e;
         bit [31:0] a;
         int        nbytes;
         e = '0;
         case (r.action) inside
            ACT_READ, ACT_WRITE: begin
               nbytes = (r.size_code == SIZE_BYTE) ? 1 : (r.size_code == SIZE_HALF) ? 2 : 4;
               a = remap(r.addr);
               e.fault = access_fault(a, nbytes, r.action == ACT_WRITE);
               if (e.fault == FAULT_NONE) begin
                  for (int k = 0; k < nbytes; k++) begin
                     if (r.action == ACT_READ) e.read_data[8*k +: 8] = peek_byte(a + k);
                     else poke_byte(a + k, r.write_data[8*k +: 8]);
                  end
               end
            end
            ACT_RAW_LOAD: begin
               for (int k = 0; k < 4; k++) poke_byte(r.addr + k, r.write_data[8*k +: 8]);
            end
            ACT_MAP_ADD: begin
               e.fault = FAULT_MAP_FULL;
               for (int i = 0; i < MAP_SLOTS; i++) begin
                  if (win_len[i] == 0) begin
                     src_base[i]  = r.addr;
                     dst_base[i]  = r.map_target;
                     win_len[i]   = r.map_length;
                     e.slot_index = 2'(i);
                     e.fault      = FAULT_NONE;
                     break;
                  end
               end
            end
            ACT_MAP_REMOVE: begin
               if (r.map_slot < MAP_SLOTS) win_len[r.map_slot] = '0;
            end
            default: ;
         endcase
         pending_rsp.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            report("response with no request pending", got.read_data, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data)
               report("read_data", got.read_data, want.read_data);
            if (got.fault !== want.fault) report("fault", got.fault, want.fault);
            if (got.slot_index !== want.slot_index)
               report("slot_index", got.slot_index, want.slot_index);
         end
      endtask
   endclass

   access_scoreboard board = new();

   remapped_checked_memory_port_core #(
      .MAP_SLOTS(MAP_SLOTS),
      .ROM_WORDS(ROM_WORDS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly no gap, some short, a few long; none while calm
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(0, 255);
         2:       return $urandom_range(0, ROM_END - 1);
         3:       return ROM_END - 8 + $urandom_range(0, 15);
         4, 5:    return RAM_BASE + $urandom_range(0, 255);
         6:       return RAM_LIMIT - 8 + $urandom_range(0, 15);
         7:       return {4'($urandom_range(0, 15)), 28'($urandom)};
         8:       return MAP_SRC_AREA + $urandom_range(0, 1023);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_target();
      case ($urandom_range(0, 5))
         0:       return 32'($urandom_range(0, 63)) * 4;
         1, 2:    return RAM_BASE + 32'($urandom_range(0, 63)) * 4;
         3:       return RAM_LIMIT - 32'($urandom_range(1, 16)) * 4;
         4:       return {4'($urandom_range(0, 15)), 28'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type make_req(logic [2:0] act, logic [31:0] addr, logic [1:0] size,
                                        logic [31:0] wdata, logic [31:0] target = '0,
                                        logic [31:0] length = '0, logic [1:0] slot = '0);
      req_type r;
      r.action     = act;
      r.addr       = addr;
      r.size_code  = size;
      r.write_data = wdata;
      r.map_target = target;
      r.map_length = length;
      r.map_slot   = slot;
      return r;
   endfunction

   function automatic req_type make_random_req();
      req_type r;
      int      roll;
      r = make_req(ACT_READ, pick_addr(), 2'($urandom_range(0, 3)), $urandom, $urandom,
                   $urandom, 2'($urandom_range(0, 3)));
      roll = $urandom_range(0, 99);
      if (roll < 34) r.action = ACT_READ;
      else if (roll < 58) r.action = ACT_WRITE;
      else if (roll < 70) r.action = ACT_RAW_LOAD;
      else if (roll < 81) r.action = ACT_MAP_ADD;
      else if (roll < 93) r.action = ACT_MAP_REMOVE;
      else r.action = ACT_MAP_REMOVE + 3'($urandom_range(1, 3));

      // align most accesses so they get past the alignment check
      if ((r.action == ACT_READ || r.action == ACT_WRITE) && $urandom_range(0, 3) != 0) begin
         if (r.size_code == SIZE_HALF) r.addr[0] = 1'b0;
         else if (r.size_code != SIZE_BYTE) r.addr[1:0] = 2'b00;
      end

      if (r.action == ACT_MAP_ADD) begin
         case ($urandom_range(0, 7))
            0:       r.map_length = '0;
            1:       r.map_length = '1;
            2:       ;
            default: r.map_length = $urandom_range(4, 1024);
         endcase
         if ($urandom_range(0, 3) != 0) r.addr = MAP_SRC_AREA + $urandom_range(0, 3) * 256;
         r.map_target = pick_target();
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stall the result channel in bursts
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         hold = pick_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_type plan [$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      calm      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(make_req(ACT_RAW_LOAD, 32'h0, SIZE_BYTE, 32'h8765_4321));
      plan.push_back(make_req(ACT_READ, 32'h0, SIZE_WORD, '0));
      plan.push_back(make_req(ACT_READ, 32'h3, SIZE_BYTE, '0));
      plan.push_back(make_req(ACT_READ, 32'h0, SIZE_ODD, '0));
      plan.push_back(make_req(ACT_READ, 32'h1, SIZE_HALF, '0));
      // alignment is checked ahead of the ROM write check
      plan.push_back(make_req(ACT_WRITE, 32'h1, SIZE_HALF, 32'h1234_5678));
      plan.push_back(make_req(ACT_WRITE, 32'h100, SIZE_WORD, 32'hDEAD_BEEF));
      plan.push_back(make_req(ACT_WRITE, RAM_BASE, SIZE_WORD, 32'hFFFF_FFFF));
      plan.push_back(make_req(ACT_WRITE, RAM_BASE + 1, SIZE_BYTE, 32'hFFFF_FF00));
      plan.push_back(make_req(ACT_READ, RAM_BASE, SIZE_WORD, '0));
      plan.push_back(make_req(ACT_READ, RAM_LIMIT, SIZE_WORD, '0));
      plan.push_back(make_req(ACT_WRITE, {REGION_RAM_HI, 28'h0}, SIZE_WORD, 32'h1));
      plan.push_back(make_req(ACT_WRITE, 32'hF000_0000, SIZE_WORD, 32'h5A5A_5A5A));
      // raw loads that wrap the address space and straddle the store ends
      plan.push_back(make_req(ACT_RAW_LOAD, 32'hFFFF_FFFE, SIZE_WORD, 32'hCAFE_BABE));
      plan.push_back(make_req(ACT_RAW_LOAD, ROM_END - 2, SIZE_WORD, 32'hA1B2_C3D4));
      plan.push_back(make_req(ACT_RAW_LOAD, RAM_LIMIT - 2, SIZE_WORD, 32'h0F1E_2D3C));
      plan.push_back(make_req(ACT_READ, 32'h0, SIZE_WORD, '0));
      // zero length reports a slot but leaves it free
      plan.push_back(make_req(ACT_MAP_ADD, MAP_SRC_AREA, SIZE_BYTE, '0, RAM_BASE, '0));
      plan.push_back(make_req(ACT_MAP_ADD, MAP_SRC_AREA, SIZE_BYTE, '0, RAM_BASE + 32'h40,
                              32'h100));
      plan.push_back(make_req(ACT_WRITE, MAP_SRC_AREA + 8, SIZE_WORD, 32'h0BAD_F00D));
      plan.push_back(make_req(ACT_READ, RAM_BASE + 32'h48, SIZE_WORD, '0));
      plan.push_back(make_req(ACT_MAP_ADD, 32'h0, SIZE_BYTE, '0, RAM_BASE, '1));
      plan.push_back(make_req(ACT_READ, 32'h4, SIZE_WORD, '0));
      plan.push_back(make_req(ACT_MAP_ADD, 32'h5000_0000, SIZE_BYTE, '0, 32'h0, 32'h10));
      plan.push_back(make_req(ACT_MAP_ADD, 32'h6000_0000, SIZE_BYTE, '0, 32'h0, 32'h10));
      plan.push_back(make_req(ACT_MAP_ADD, 32'h7000_0000, SIZE_BYTE, '0, 32'h0, 32'h10));
      plan.push_back(make_req(ACT_MAP_REMOVE, '0, SIZE_BYTE, '0, '0, '0, 2'd1));
      plan.push_back(make_req(ACT_MAP_REMOVE, '0, SIZE_BYTE, '0, '0, '0, 2'd1));
      plan.push_back(make_req(ACT_MAP_REMOVE + 3'd3, '1, SIZE_ODD, '1, '1, '1, 2'd3));

      foreach (plan[i]) send_request(plan[i]);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         send_request(make_random_req());
      end
      req_valid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rcmp_pkg.sv
rtl/rcmp_map_table.sv
rtl/rcmp_store.sv
rtl/remapped_checked_memory_port_core.sv
dv/tb_remapped_checked_memory_port_core.sv
